/* rtl/pwpd_pkg.sv */
package pwpd_pkg;

   // Field widths of the edge items, the results and the registers.
   localparam int unsigned DURATION_W = 20;
   localparam int unsigned ADDRESS_W  = 8;
   localparam int unsigned VALUE_W    = 4;
   localparam int unsigned WORD_W     = 16;
   localparam int unsigned SHIFT_W    = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_IDX_W  = 2;

   // Register indexes on the configuration port (byte address is four times the index).
   localparam logic [CSR_IDX_W-1:0] REG_LISTEN_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_LIMIT  = 2'd2;

   // Register values after reset.
   localparam logic [ADDRESS_W-1:0]  LISTEN_ADDRESS_RESET = 8'd0;
   localparam logic [DURATION_W-1:0] SHORT_LIMIT_RESET    = 20'd500;
   localparam logic [DURATION_W-1:0] TIMEOUT_LIMIT_RESET  = 20'd4000;

   // Command codes and line levels.
   localparam logic CMD_EDGE   = 1'b0;
   localparam logic CMD_READ   = 1'b1;
   localparam logic LEVEL_HIGH = 1'b1;

   // Address field sits in bits 15:8 of the frame word, the value in bits 7:4.
   localparam int unsigned ADDRESS_LSB = 8;
   localparam int unsigned VALUE_LSB   = 4;

   typedef struct packed {
      logic                  cmd;
      logic                  level;
      logic [DURATION_W-1:0] duration;
   } req_item_type;

   typedef struct packed {
      logic [ADDRESS_W-1:0] pkt_address;
      logic [VALUE_W-1:0]   pkt_value;
      logic                 ready_res;
      logic                 stored_now;
   } rsp_item_type;

endpackage

/* rtl/pulse_width_packet_decoder.sv */
// Pulse-width coded packet decoder.
// Edge items arrive on the req_ channel: cmd selects a line edge or a read of
// the stored packet, level is the line level after the edge and duration the
// time in microseconds since the previous edge. Every item gives exactly one
// result on the rsp_ channel with the stored packet, the ready flag and a
// flag that marks the edge which stored a new packet.
// An accepted item's result goes to the result register, or to the skid register
// while a shown result is held; one item is taken in every cycle while req_stall
// is low: decoding is a single compare, shift and match pass before the registers.
// The result register is backed by a one-item skid register, so a stall on
// rsp_ holds the shown result while one more item is still taken; req_stall
// rises only once the skid register is full, and it comes from a register.
// Reset clears the framing state, the stored packet and the ready flag,
// empties both result registers and loads the register defaults (listen
// address zero, short limit 500, timeout limit 4000).
// The csr_ port is APB-style, always ready; registers lie at byte addresses 0, 4 and 8.
// They are to be written only while no item is in flight; the block does not check.
module pulse_width_packet_decoder #(
   parameter int unsigned FRAME_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pwpd_pkg::req_item_type             req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pwpd_pkg::rsp_item_type             rsp_item,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pwpd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pwpd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pwpd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import pwpd_pkg::*;

   localparam int unsigned POS_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BITS - 1);

   // Configuration registers.
   logic [ADDRESS_W-1:0]  listen_address_ff;
   logic [DURATION_W-1:0] short_limit_ff;
   logic [DURATION_W-1:0] timeout_limit_ff;

   // Decoder state.
   logic                  frame_active_ff, frame_active_in;
   logic [POS_W-1:0]      bit_position_ff, bit_position_in;
   logic [WORD_W-1:0]     shift_word_ff, shift_word_in;
   logic [ADDRESS_W-1:0]  stored_address_ff, stored_address_in;
   logic [VALUE_W-1:0]    stored_value_ff, stored_value_in;
   logic                  ready_flag_ff, ready_flag_in;

   // Result register and skid register.
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;
   logic                  skid_valid_ff, skid_valid_in;
   rsp_item_type          skid_item_ff, skid_item_in;

   logic                  accept;
   logic                  rsp_take;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic                  pulse_bit;
   logic [SHIFT_W-1:0]    shift_amount;
   logic [WORD_W-1:0]     word_filled;
   logic [ADDRESS_W-1:0]  frame_address;
   logic [VALUE_W-1:0]    frame_value;
   logic                  stored;
   logic                  ready_out;
   rsp_item_type          result;

   assign accept    = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Configuration port: writes complete in the access phase, reads are direct.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_address_ff <= LISTEN_ADDRESS_RESET;
         short_limit_ff    <= SHORT_LIMIT_RESET;
         timeout_limit_ff  <= TIMEOUT_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_LISTEN_ADDRESS: listen_address_ff <= csr_pwdata[ADDRESS_W-1:0];
            REG_SHORT_LIMIT:    short_limit_ff    <= csr_pwdata[DURATION_W-1:0];
            REG_TIMEOUT_LIMIT:  timeout_limit_ff  <= csr_pwdata[DURATION_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LISTEN_ADDRESS: csr_prdata = CSR_DATA_W'(listen_address_ff);
         REG_SHORT_LIMIT:    csr_prdata = CSR_DATA_W'(short_limit_ff);
         REG_TIMEOUT_LIMIT:  csr_prdata = CSR_DATA_W'(timeout_limit_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // Pulse classification and the frame word with the new bit placed from the top.
   assign pulse_bit     = (req_item.duration < short_limit_ff);
   assign shift_amount  = SHIFT_W'(WORD_W - 1) - SHIFT_W'(bit_position_ff);
   assign word_filled   = shift_word_ff | (WORD_W'(pulse_bit) << shift_amount);
   assign frame_address = word_filled[ADDRESS_LSB +: ADDRESS_W];
   assign frame_value   = word_filled[VALUE_LSB +: VALUE_W];

   // One decode step per accepted item.
   always_comb begin
      frame_active_in   = frame_active_ff;
      bit_position_in   = bit_position_ff;
      shift_word_in     = shift_word_ff;
      stored_address_in = stored_address_ff;
      stored_value_in   = stored_value_ff;
      ready_flag_in     = ready_flag_ff;
      stored            = 1'b0;
      ready_out         = ready_flag_ff;
      if (req_item.cmd == CMD_READ) begin
         ready_flag_in = 1'b0;
      end else if (req_item.level == LEVEL_HIGH) begin
         // A long gap before a rising edge drops any frame in progress.
         if (req_item.duration > timeout_limit_ff) begin
            frame_active_in = 1'b0;
            bit_position_in = '0;
         end
      end else if (!frame_active_ff) begin
         // A zero bit while idle is the start bit.
         if (!pulse_bit) begin
            frame_active_in = 1'b1;
            bit_position_in = '0;
            shift_word_in   = '0;
         end
      end else begin
         shift_word_in = word_filled;
         if (bit_position_ff >= LAST_POS) begin
            frame_active_in = 1'b0;
            bit_position_in = '0;
            if ((listen_address_ff == '0 || listen_address_ff == frame_address) &&
                stored_value_ff != frame_value) begin
               stored_address_in = frame_address;
               stored_value_in   = frame_value;
               ready_flag_in     = 1'b1;
               stored            = 1'b1;
            end
         end else begin
            bit_position_in = bit_position_ff + POS_W'(1);
         end
      end
      if (req_item.cmd == CMD_EDGE) begin
         ready_out = ready_flag_in;
      end
   end

   always_comb begin
      result.pkt_address = stored_address_in;
      result.pkt_value   = stored_value_in;
      result.ready_res   = ready_out;
      result.stored_now  = stored;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff   <= 1'b0;
         bit_position_ff   <= '0;
         shift_word_ff     <= '0;
         stored_address_ff <= '0;
         stored_value_ff   <= '0;
         ready_flag_ff     <= 1'b0;
      end else if (accept) begin
         frame_active_ff   <= frame_active_in;
         bit_position_ff   <= bit_position_in;
         shift_word_ff     <= shift_word_in;
         stored_address_ff <= stored_address_in;
         stored_value_ff   <= stored_value_in;
         ready_flag_ff     <= ready_flag_in;
      end
   end

   // Result register with a skid register behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_item_in   = rsp_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_item_in  = result;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff  <= rsp_item_in;
      skid_item_ff <= skid_item_in;
   end

   // The skid register only fills behind a result that is being held.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while the result register is empty");

   // A packet reported as stored always leaves the ready flag set.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.stored_now) |-> rsp_item_ff.ready_res)
      else $error("stored packet reported without the ready flag");

   // A read command always clears the ready flag.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.cmd == CMD_READ) |=> !ready_flag_ff)
      else $error("ready flag survived a read command");

   // The bit position is only away from zero inside a frame.
   assert property (@(posedge clock) disable iff (reset)
      !frame_active_ff |-> (bit_position_ff == '0))
      else $error("bit position moved while idle");

   // Every accepted item leaves a result behind it in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

endmodule
